### design/aes_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// AES package
// S-box, round constants and round helper functions shared by the round cells.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int NumRounds = 10;
    localparam int RoundIdxW = 4;

    typedef logic [7:0]   byte_t;
    typedef logic [127:0] block_t;
    typedef logic [RoundIdxW-1:0] round_idx_t;

    typedef enum logic [0:0] {
        CFG_KEY_HIGH = 1'b0,
        CFG_KEY_LOW  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic   valid;
        block_t state;
        block_t key;
    } stage_t;

    function automatic byte_t sbox(input byte_t x);
        byte_t r;
        case (x)
            8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
            8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
            8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
            8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
            8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
            8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
            8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
            8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
            8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
            8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
            8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
            8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
            8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
            8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
            8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
            8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
            8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
            8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
            8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
            8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
            8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
            8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
            8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
            8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
            8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
            8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
            8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
            8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
            8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
            8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
            8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
            8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
            8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
            8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
            8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
            8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
            8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
            8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
            8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
            8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
            8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
            8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
            8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
            8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
            8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
            8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
            8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
            8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
            8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
            8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
            8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
            8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
            8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
            8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
            8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
            8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
            8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
            8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
            8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
            8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
            8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
            8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
            8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
            8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic byte_t rcon(input round_idx_t rnd);
        byte_t r;
        case (rnd)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic byte_t gf_dbl(input byte_t x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Block byte n sits at bits [127-8n -: 8]
    function automatic byte_t get_byte(input block_t b, input int n);
        return b[127 - 8 * n -: 8];
    endfunction

    function automatic block_t next_round_key(input block_t k, input round_idx_t rnd);
        logic [31:0] w0, w1, w2, w3, t;
        block_t      r;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {sbox(w3[23:16]) ^ rcon(rnd), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        r  = {w0, w1, w2, w3};
        return r;
    endfunction

    function automatic block_t sub_shift(input block_t b);
        block_t r;
        for (int c = 0; c < 4; c++) begin
            for (int rw = 0; rw < 4; rw++) begin
                r[127 - 8 * (4 * c + rw) -: 8] = sbox(get_byte(b, 4 * ((c + rw) % 4) + rw));
            end
        end
        return r;
    endfunction

    function automatic block_t mix_cols(input block_t b);
        block_t r;
        byte_t  a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++) begin
            a0  = get_byte(b, 4 * c);
            a1  = get_byte(b, 4 * c + 1);
            a2  = get_byte(b, 4 * c + 2);
            a3  = get_byte(b, 4 * c + 3);
            all = a0 ^ a1 ^ a2 ^ a3;
            r[127 - 32 * c -: 32] = {a0 ^ all ^ gf_dbl(a0 ^ a1), a1 ^ all ^ gf_dbl(a1 ^ a2),
                                     a2 ^ all ^ gf_dbl(a2 ^ a3), a3 ^ all ^ gf_dbl(a3 ^ a0)};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### design/aes_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// AES block stream interface
// Valid/ready channel carrying one 128-bit block as two 64-bit halves.
// ----------------------------------------------------------------------------
interface aes_stream_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_high;
    logic [63:0] data_low;

    modport source (output valid, output data_high, output data_low, input ready);
    modport sink   (input valid, input data_high, input data_low, output ready);
endinterface
`default_nettype wire

### design/aes_round_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// AES round cell
// One round plus its key step; hands state and key to the next cell on advance.
// ----------------------------------------------------------------------------
module aes_round_cell (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  advance,
    input  wire aes_pkg::round_idx_t   rnd,
    input  wire aes_pkg::stage_t       prev,
    output aes_pkg::stage_t            cur
);
    import aes_pkg::*;

    logic   valid_reg;
    block_t state_reg, key_reg;
    block_t key_next, state_next, sub;

    always_comb
    begin
        key_next = next_round_key(prev.key, rnd);
        sub      = sub_shift(prev.state);
        // last round skips the column mix
        if (rnd == round_idx_t'(NumRounds))
            state_next = sub ^ key_next;
        else
            state_next = mix_cols(sub) ^ key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= prev.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

    assign cur = '{valid: valid_reg, state: state_reg, key: key_reg};
endmodule
`default_nettype wire

### design/aes128_block_encrypt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 block encrypt
// Pipelined ECB encryptor with round keys computed alongside the data.
// ----------------------------------------------------------------------------
// One block is taken every cycle while the output side takes results. A
// request passes an input stage (initial key addition) and ten round cells
// before its ciphertext appears; each cell carries its own round key, so a key
// written while idle applies to the next block accepted.
// The whole chain stalls together when the output is held.
module aes128_block_encrypt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    aes_stream_if.sink       plain,
    aes_stream_if.source     cipher
);
    import aes_pkg::*;

    logic [63:0] key_high_reg, key_low_reg;
    logic        advance;
    logic        in_valid_reg;
    block_t      in_state_reg, in_key_reg;
    stage_t      chain [0:NumRounds];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                default:      key_high_reg <= key_high_reg;
            endcase
        end
    end

    // advance when the last cell is empty or its result is taken
    assign advance     = !chain[NumRounds].valid || cipher.ready;
    assign plain.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (advance)
            in_valid_reg <= plain.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_state_reg <= {plain.data_high, plain.data_low} ^ {key_high_reg, key_low_reg};
            in_key_reg   <= {key_high_reg, key_low_reg};
        end
    end

    assign chain[0] = '{valid: in_valid_reg, state: in_state_reg, key: in_key_reg};

    for (genvar g = 1; g <= NumRounds; g++)
    begin : g_round
        aes_round_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .rnd     (round_idx_t'(g)),
            .prev    (chain[g-1]),
            .cur     (chain[g])
        );
    end

    assign cipher.valid     = chain[NumRounds].valid;
    assign cipher.data_high = chain[NumRounds].state[127:64];
    assign cipher.data_low  = chain[NumRounds].state[63:0];
endmodule
`default_nettype wire

### design/aes128_block_encrypt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 block encrypt checker
// Port-level properties of the encryptor, bound to the top level.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [63:0] out_high,
    input wire logic [63:0] out_low
);
    // a stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_high) && $stable(out_low))
        else $error("stalled result changed");

    // input side frees up whenever the output is drained
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked while output drains");

    // input stalls only when a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without backpressure");

    // nothing comes out as reset is released
    assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("result right after reset");
endmodule

bind aes128_block_encrypt aes128_block_encrypt_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (plain.ready),
    .out_valid (cipher.valid),
    .out_ready (cipher.ready),
    .out_high  (cipher.data_high),
    .out_low   (cipher.data_low)
);
`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// AES-128 block encrypt testbench
// Drives plaintext blocks under several keys, predicts each ciphertext with a
// behavioural AES-128 encryptor and checks results in order, with random stalls.
// ----------------------------------------------------------------------------
module tb;
    import aes_pkg::*;

    typedef logic [127:0] blk128_t;
    typedef logic [7:0]   oct_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = CFG_KEY_HIGH;
    logic [63:0] cfg_data = '0;

    aes_stream_if plain_ch ();
    aes_stream_if cipher_ch ();

    aes128_block_encrypt i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .plain     (plain_ch.sink),
        .cipher    (cipher_ch.source)
    );

    always #5 clk = ~clk;

    oct_t sb [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    oct_t rc [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

    logic [63:0] key_hi_q = '0;
    logic [63:0] key_lo_q = '0;
    blk128_t     ciphertexts_due [$];
    int          errors = 0;
    int          n_blocks = 0;
    int          n_keys = 0;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    bit          hold_sink = 1'b0;

    function automatic oct_t xt(oct_t x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte n of a block is bits [127-8n -: 8]
    function automatic blk128_t encrypt_block(blk128_t pt);
        oct_t    w [176];
        oct_t    s [16];
        oct_t    t [16];
        oct_t    tmp [4];
        oct_t    hold, all;
        blk128_t k, r;
        k = {key_hi_q, key_lo_q};
        for (int n = 0; n < 16; n++)
        begin
            w[n] = k[127 - 8 * n -: 8];
            s[n] = pt[127 - 8 * n -: 8];
        end
        for (int i = 4; i < 44; i++)
        begin
            for (int n = 0; n < 4; n++)
                tmp[n] = w[4 * (i - 1) + n];
            if (i % 4 == 0)
            begin
                hold = tmp[0];
                tmp[0] = sb[tmp[1]] ^ rc[i / 4 - 1];
                tmp[1] = sb[tmp[2]];
                tmp[2] = sb[tmp[3]];
                tmp[3] = sb[hold];
            end
            for (int n = 0; n < 4; n++)
                w[4 * i + n] = w[4 * (i - 4) + n] ^ tmp[n];
        end
        for (int n = 0; n < 16; n++)
            s[n] ^= w[n];
        for (int rnd = 1; rnd <= 10; rnd++)
        begin
            for (int c = 0; c < 4; c++)
                for (int rw = 0; rw < 4; rw++)
                    t[4 * c + rw] = sb[s[4 * ((c + rw) % 4) + rw]];
            s = t;
            if (rnd < 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    all = s[4*c] ^ s[4*c+1] ^ s[4*c+2] ^ s[4*c+3];
                    t[4*c]   = s[4*c]   ^ all ^ xt(s[4*c]   ^ s[4*c+1]);
                    t[4*c+1] = s[4*c+1] ^ all ^ xt(s[4*c+1] ^ s[4*c+2]);
                    t[4*c+2] = s[4*c+2] ^ all ^ xt(s[4*c+2] ^ s[4*c+3]);
                    t[4*c+3] = s[4*c+3] ^ all ^ xt(s[4*c+3] ^ s[4*c]);
                end
                s = t;
            end
            for (int n = 0; n < 16; n++)
                s[n] ^= w[16 * rnd + n];
        end
        for (int n = 0; n < 16; n++)
            r[127 - 8 * n -: 8] = s[n];
        return r;
    endfunction

    task automatic write_key(cfg_index_t idx, logic [63:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_KEY_HIGH)
            key_hi_q = val;
        else
            key_lo_q = val;
        n_keys++;
    endtask

    // wait for the pipeline to drain before touching the key
    task automatic drain();
        while (ciphertexts_due.size() != 0)
            @(negedge clk);
        repeat (15) @(negedge clk);
    endtask

    // offer one request at the falling edge; hold it until accepted
    task automatic send_block(blk128_t pt, blk128_t known, bit has_known);
        blk128_t exp;
        while ($urandom_range(99) < src_idle_pct)
        begin
            plain_ch.valid <= 1'b0;
            @(negedge clk);
        end
        plain_ch.valid     <= 1'b1;
        plain_ch.data_high <= pt[127:64];
        plain_ch.data_low  <= pt[63:0];
        do
            @(posedge clk);
        while (!plain_ch.ready);
        exp = encrypt_block(pt);
        if (has_known && exp !== known)
        begin
            $error("directed vector: expected %h, predictor gives %h", known, exp);
            errors++;
        end
        ciphertexts_due.push_back(exp);
        n_blocks++;
        @(negedge clk);
    endtask

    task automatic idle_source();
        plain_ch.valid <= 1'b0;
    endtask

    // sink side: random stall, or a long hold-off when requested
    initial
    begin
        cipher_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            cipher_ch.ready <= !hold_sink && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        blk128_t exp;
        if (rst_n && cipher_ch.valid && cipher_ch.ready)
        begin
            if (ciphertexts_due.size() == 0)
            begin
                $error("unexpected ciphertext %h_%h", cipher_ch.data_high, cipher_ch.data_low);
                errors++;
            end
            else
            begin
                exp = ciphertexts_due.pop_front();
                if (cipher_ch.data_high !== exp[127:64])
                begin
                    $error("cipher_high: expected %h, got %h", exp[127:64],
                        cipher_ch.data_high);
                    errors++;
                end
                if (cipher_ch.data_low !== exp[63:0])
                begin
                    $error("cipher_low: expected %h, got %h", exp[63:0],
                        cipher_ch.data_low);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

    typedef struct {
        blk128_t pt;
        blk128_t ct;
        bit      has_ct;
    } vec_t;

    vec_t dir_tab [] = '{
        // known answers are under the standard test key, loaded below
        '{128'h3243f6a8885a308d313198a2e0370734, 128'h3925841d02dc09fbdc118597196a0b32, 1},
        '{128'h0, 128'h0, 0},
        '{{128{1'b1}}, 128'h0, 0},
        '{128'h80000000000000000000000000000000, 128'h0, 0},
        '{128'h00000000000000000000000000000001, 128'h0, 0},
        '{128'haaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa, 128'h0, 0},
        '{128'h55555555555555555555555555555555, 128'h0, 0}
    };

    initial
    begin
        blk128_t pt;
        plain_ch.valid     = 1'b0;
        plain_ch.data_high = '0;
        plain_ch.data_low  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero key straight after reset: known answer for the zero block
        send_block(128'h0, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e, 1);
        idle_source();
        drain();
        write_key(CFG_KEY_HIGH, 64'h2b7e151628aed2a6);
        write_key(CFG_KEY_LOW, 64'habf7158809cf4f3c);
        foreach (dir_tab[i])
            send_block(dir_tab[i].pt, dir_tab[i].ct, dir_tab[i].has_ct);
        idle_source();
        drain();
        write_key(CFG_KEY_HIGH, 64'hffffffffffffffff);
        write_key(CFG_KEY_LOW, 64'hffffffffffffffff);
        for (int i = 0; i < 4; i++)
            send_block({$urandom, $urandom, $urandom, $urandom}, 128'h0, 0);

        // long receiver hold-off: fill the pipeline and stall the input
        idle_source();
        drain();
        fork
            begin
                hold_sink = 1'b1;
                repeat (60) @(negedge clk);
                hold_sink = 1'b0;
            end
            for (int i = 0; i < 20; i++)
                send_block({$urandom, $urandom, $urandom, $urandom}, 128'h0, 0);
        join

        for (int ph = 0; ph < 6; ph++)
        begin
            idle_source();
            drain();
            write_key(CFG_KEY_HIGH, {$urandom, $urandom});
            write_key(CFG_KEY_LOW, {$urandom, $urandom});
            src_idle_pct = (ph < 2) ? 15 : (ph < 4) ? 55 : 0;
            snk_idle_pct = (ph < 2) ? 55 : (ph < 4) ? 15 : 0;
            for (int i = 0; i < 62; i++)
            begin
                pt = {$urandom, $urandom, $urandom, $urandom};
                if ($urandom_range(15) == 0)
                    pt = $urandom_range(1) ? 128'h0 : {128{1'b1}};
                send_block(pt, 128'h0, 0);
            end
        end
        idle_source();
        snk_idle_pct = 0;

        fork
            while (ciphertexts_due.size() != 0)
                @(negedge clk);
            repeat (100000) @(negedge clk);
        join_any
        repeat (20) @(negedge clk);
        $display("Encrypted %0d blocks over %0d key writes, with stalls on both sides.",
            n_blocks, n_keys);
        if (errors == 0 && ciphertexts_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
